FILE: rtl/dual_slot_record_validator_macros.svh
// assertion macros for the dual slot record validator checker
`ifndef DUAL_SLOT_RECORD_VALIDATOR_MACROS_SVH
`define DUAL_SLOT_RECORD_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define DSRV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsrv same-cycle check failed");

// next-cycle implication, disabled in reset
`define DSRV_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsrv next-cycle check failed");

`endif

FILE: rtl/dsrv_pkg.sv
// types, constants and helper functions of the dual slot record validator
package dsrv_pkg;

  localparam int HEADER_BYTES     = 20;
  localparam int MAX_RECORD_BYTES = 4096;
  localparam int COUNT_W          = 13;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 32;
  localparam int PAYLOAD_W        = 12;
  localparam int HDR_W            = HEADER_BYTES * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [31:0]        REC_MAGIC   = 32'h4350_524D;
  localparam logic [15:0]        REC_VERSION = 16'd1;
  localparam logic [31:0]        CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0]        CRC_POLY    = 32'hEDB8_8320;

  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_REVISION = 1'd1;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_DECIDE = 2'd1,
    OP_SAVE   = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHECK    = 2'd0,
    KIND_DECISION = 2'd1,
    KIND_PLAN     = 2'd2,
    KIND_COMMIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_DEFAULTS = 2'd1,
    ACT_REPAIR   = 2'd2,
    ACT_SAVE     = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    SRC_DEFAULTS = 2'd0,
    SRC_SLOT0    = 2'd1,
    SRC_SLOT1    = 2'd2,
    SRC_UNUSED   = 2'd3
  } src_t;

  typedef struct packed {
    op_t        op;
    logic       slot;
    logic [7:0] data;
    logic       last;
    logic       wok;
    logic       has_result;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] next_seq(input logic [31:0] s);
    logic [31:0] n;
    n = s + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

endpackage

FILE: rtl/dual_slot_record_validator.sv
// top level of the dual slot record validator
// An item is taken at a clock edge where start is high and busy is low, one item per
// cycle while busy is low. Each item passes through a short queue and reaches the
// back end on the following cycle, where record bytes update a byte-wide CRC-32 and
// the header fields, and selection, save and commit items are resolved in that single
// cycle. A result is registered and shows on the result ports with done high for
// exactly one cycle; between the item being taken and done lie the queue register and
// the result register. A record byte gives a result only when last_byte is set. The
// back end drains one item every cycle, so busy only rises if the queue fills.
// Results cannot be held off by the receiver.
module dual_slot_record_validator #(
  parameter int QUEUE_DEPTH = dsrv_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode,
  input  logic                             slot,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  logic                             write_ok,
  input  logic                             wr_en,
  input  logic [dsrv_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [dsrv_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic                             done,
  output logic [1:0]                       result_kind,
  output logic                             slot_ok,
  output logic [1:0]                       action,
  output logic                             write_slot,
  output logic [31:0]                      write_sequence,
  output logic [1:0]                       active_source,
  output logic [31:0]                      active_sequence,
  output logic                             use_defaults
);
  import dsrv_pkg::*;

  item_t in_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  head_valid;

  dsrv_front u_front (
    .start     (start),
    .full      (full),
    .opcode    (opcode),
    .slot      (slot),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .write_ok  (write_ok),
    .busy      (busy),
    .push      (push),
    .item      (in_item)
  );

  dsrv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (in_item),
    .pop       (pop),
    .rd_item   (head_item),
    .not_empty (head_valid),
    .full      (full)
  );

  dsrv_back u_back (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .item_valid      (head_valid),
    .item            (head_item),
    .pop             (pop),
    .done            (done),
    .result_kind     (result_kind),
    .slot_ok         (slot_ok),
    .action          (action),
    .write_slot      (write_slot),
    .write_sequence  (write_sequence),
    .active_source   (active_source),
    .active_sequence (active_sequence),
    .use_defaults    (use_defaults)
  );

endmodule

FILE: rtl/dsrv_front.sv
// front end: accepts items and classifies them for the back end
module dsrv_front (
  input  logic               start,
  input  logic               full,
  input  logic [1:0]         opcode,
  input  logic               slot,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               write_ok,
  output logic               busy,
  output logic               push,
  output dsrv_pkg::item_t    item
);
  import dsrv_pkg::*;

  op_t op;

  assign op   = op_t'(opcode);
  assign busy = full;
  assign push = start && !full;

  always_comb begin
    item.op   = op;
    item.slot = slot;
    item.data = data_byte;
    item.last = last_byte;
    item.wok  = write_ok;
    unique case (op)
      OP_BYTE: item.has_result = last_byte;
      default: item.has_result = 1'b1;
    endcase
  end

endmodule

FILE: rtl/dsrv_queue.sv
// short item queue between front and back end
module dsrv_queue #(
  parameter int DEPTH = dsrv_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dsrv_pkg::item_t wr_item,
  input  logic            pop,
  output dsrv_pkg::item_t rd_item,
  output logic            not_empty,
  output logic            full
);
  import dsrv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == FULL_CNT);
  assign rd_item   = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/dsrv_back.sv
// back end: record checking, slot selection, write planning and commit
module dsrv_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [dsrv_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [dsrv_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic                               item_valid,
  input  dsrv_pkg::item_t                    item,
  output logic                               pop,
  output logic                               done,
  output logic [1:0]                         result_kind,
  output logic                               slot_ok,
  output logic [1:0]                         action,
  output logic                               write_slot,
  output logic [31:0]                        write_sequence,
  output logic [1:0]                         active_source,
  output logic [31:0]                        active_sequence,
  output logic                               use_defaults
);
  import dsrv_pkg::*;

  logic [PAYLOAD_W-1:0] payload_bytes;
  logic [31:0]          code_revision;

  logic [31:0]        crc, crc_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [HDR_W-1:0]   hdr, hdr_next;
  logic [31:0]        slot_seq [2];
  logic [31:0]        slot_seq_next [2];
  logic [31:0]        slot_rev [2];
  logic [31:0]        slot_rev_next [2];
  logic [1:0]         slot_vld, slot_vld_next;
  src_t               cur_src, cur_src_next;
  logic [31:0]        cur_seq, cur_seq_next;
  logic               pend_vld, pend_vld_next;
  logic               pend_slot, pend_slot_next;
  logic [31:0]        pend_seq, pend_seq_next;

  kind_t       res_kind;
  logic        res_ok;
  act_t        res_act;
  logic        res_wslot;
  logic [31:0] res_wseq;

  // record byte path
  logic [COUNT_W-1:0] count_inc;
  logic [HDR_W-1:0]   hdr_upd;
  logic [31:0]        crc_upd;
  logic [COUNT_W-1:0] expect_count;
  logic               rec_ok;
  logic [7:0]         bit_pos;

  // selection path
  logic        pick1, any_vld, old0, old1, sel_old;
  logic [31:0] nseq0, nseq1, nseq_cur, sel_seq, sel_nseq;

  assign pop = item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= PAYLOAD_W'(64);
      code_revision <= 32'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PAYLOAD_BYTES: payload_bytes <= wr_data[PAYLOAD_W-1:0];
        REG_CODE_REVISION: code_revision <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
    bit_pos   = {byte_count[4:0], 3'b000};
    hdr_upd   = hdr;
    crc_upd   = crc;
    if (byte_count < COUNT_W'(HEADER_BYTES)) begin
      hdr_upd[bit_pos +: 8] = item.data;
    end else begin
      crc_upd = crc_byte(crc, item.data);
    end
    expect_count = COUNT_W'(HEADER_BYTES) + {1'b0, payload_bytes};
    rec_ok = (hdr_upd[31:0] == REC_MAGIC) &&
             (hdr_upd[47:32] == REC_VERSION) &&
             (hdr_upd[63:48] == {4'd0, payload_bytes}) &&
             (count_inc == expect_count) &&
             (count_inc <= COUNT_W'(MAX_RECORD_BYTES)) &&
             (~crc_upd == hdr_upd[159:128]);
  end

  always_comb begin
    any_vld  = slot_vld[0] || slot_vld[1];
    pick1    = slot_vld[1] && (!slot_vld[0] || (slot_rev[1] > slot_rev[0]) ||
               ((slot_rev[1] == slot_rev[0]) && (slot_seq[1] > slot_seq[0])));
    old0     = slot_rev[0] < code_revision;
    old1     = slot_rev[1] < code_revision;
    nseq0    = next_seq(slot_seq[0]);
    nseq1    = next_seq(slot_seq[1]);
    nseq_cur = next_seq(cur_seq);
    sel_old  = pick1 ? old1 : old0;
    sel_seq  = pick1 ? slot_seq[1] : slot_seq[0];
    sel_nseq = pick1 ? nseq1 : nseq0;
  end

  always_comb begin
    crc_next        = crc;
    byte_count_next = byte_count;
    hdr_next        = hdr;
    slot_seq_next   = slot_seq;
    slot_rev_next   = slot_rev;
    slot_vld_next   = slot_vld;
    cur_src_next    = cur_src;
    cur_seq_next    = cur_seq;
    pend_vld_next   = pend_vld;
    pend_slot_next  = pend_slot;
    pend_seq_next   = pend_seq;
    res_kind        = KIND_CHECK;
    res_ok          = 1'b0;
    res_act         = ACT_NONE;
    res_wslot       = 1'b0;
    res_wseq        = 32'd1;
    if (item_valid) begin
      unique case (item.op)
        OP_BYTE: begin
          if (item.last) begin
            slot_vld_next[item.slot] = rec_ok;
            slot_seq_next[item.slot] = hdr_upd[95:64];
            slot_rev_next[item.slot] = hdr_upd[127:96];
            crc_next        = CRC_INIT;
            byte_count_next = '0;
            hdr_next        = '0;
            res_ok          = rec_ok;
          end else begin
            crc_next        = crc_upd;
            byte_count_next = count_inc;
            hdr_next        = hdr_upd;
          end
        end
        OP_DECIDE: begin
          res_kind      = KIND_DECISION;
          pend_vld_next = 1'b0;
          cur_src_next  = SRC_DEFAULTS;
          cur_seq_next  = 32'd0;
          if (!any_vld) begin
            pend_vld_next  = 1'b1;
            pend_slot_next = 1'b0;
            pend_seq_next  = 32'd1;
            res_act        = ACT_DEFAULTS;
          end else if (sel_old) begin
            pend_vld_next  = 1'b1;
            pend_slot_next = 1'b0;
            pend_seq_next  = sel_nseq;
            res_act        = ACT_DEFAULTS;
            res_wseq       = sel_nseq;
          end else begin
            cur_src_next = pick1 ? SRC_SLOT1 : SRC_SLOT0;
            cur_seq_next = sel_seq;
            if (slot_vld[0] != slot_vld[1]) begin
              pend_vld_next  = 1'b1;
              pend_slot_next = !pick1;
              pend_seq_next  = sel_nseq;
              res_act        = ACT_REPAIR;
              res_wslot      = !pick1;
              res_wseq       = sel_nseq;
            end
          end
        end
        OP_SAVE: begin
          res_kind      = KIND_PLAN;
          res_act       = ACT_SAVE;
          pend_vld_next = 1'b1;
          if (cur_src == SRC_DEFAULTS) begin
            pend_slot_next = 1'b0;
            pend_seq_next  = 32'd1;
          end else begin
            pend_slot_next = (cur_src != SRC_SLOT1);
            pend_seq_next  = nseq_cur;
          end
          res_wslot = pend_slot_next;
          res_wseq  = pend_seq_next;
        end
        OP_COMMIT: begin
          res_kind = KIND_COMMIT;
          if (pend_vld && item.wok) begin
            cur_src_next             = pend_slot ? SRC_SLOT1 : SRC_SLOT0;
            cur_seq_next             = pend_seq;
            slot_vld_next[pend_slot] = 1'b1;
            slot_seq_next[pend_slot] = pend_seq;
            slot_rev_next[pend_slot] = code_revision;
            res_wslot                = pend_slot;
            res_wseq                 = pend_seq;
          end
          pend_vld_next  = 1'b0;
          pend_slot_next = 1'b0;
          pend_seq_next  = 32'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      byte_count <= '0;
      hdr        <= '0;
      slot_seq   <= '{default: 32'd0};
      slot_rev   <= '{default: 32'd0};
      slot_vld   <= '0;
      cur_src    <= SRC_DEFAULTS;
      cur_seq    <= 32'd0;
      pend_vld   <= 1'b0;
      pend_slot  <= 1'b0;
      pend_seq   <= 32'd0;
      done       <= 1'b0;
    end else begin
      crc        <= crc_next;
      byte_count <= byte_count_next;
      hdr        <= hdr_next;
      slot_seq   <= slot_seq_next;
      slot_rev   <= slot_rev_next;
      slot_vld   <= slot_vld_next;
      cur_src    <= cur_src_next;
      cur_seq    <= cur_seq_next;
      pend_vld   <= pend_vld_next;
      pend_slot  <= pend_slot_next;
      pend_seq   <= pend_seq_next;
      done       <= item_valid && item.has_result;
    end
  end

  always_ff @(posedge clk) begin
    result_kind     <= res_kind;
    slot_ok         <= res_ok;
    action          <= res_act;
    write_slot      <= res_wslot;
    write_sequence  <= res_wseq;
    active_source   <= cur_src_next;
    active_sequence <= cur_seq_next;
    use_defaults    <= (cur_src_next == SRC_DEFAULTS);
  end

endmodule

FILE: rtl/dsrv_checker.sv
// port-level checker for the dual slot record validator, bound to the top level
`include "dual_slot_record_validator_macros.svh"

module dsrv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [1:0]                       opcode,
  input logic                             last_byte,
  input logic                             done,
  input logic [1:0]                       result_kind,
  input logic                             slot_ok,
  input logic [1:0]                       action,
  input logic [31:0]                      write_sequence,
  input logic [1:0]                       active_source,
  input logic                             use_defaults
);
  import dsrv_pkg::*;

  logic take_result;

  assign take_result = !rst && start && !busy &&
                       ((opcode != OP_BYTE) || last_byte);

  `DSRV_ASSERT_NXT(a_result_follows, clk, rst, $past(take_result), done)
  `DSRV_ASSERT_IMP(a_no_stray_result, clk, rst, done, $past(take_result, 2))
  `DSRV_ASSERT_IMP(a_defaults_flag, clk, rst, done,
                   use_defaults == (active_source == SRC_DEFAULTS))
  `DSRV_ASSERT_IMP(a_seq_nonzero, clk, rst, done, write_sequence != 32'd0)
  `DSRV_ASSERT_IMP(a_ok_only_check, clk, rst, done && (result_kind != KIND_CHECK),
                   !slot_ok && (action != ACT_NONE || write_sequence != 32'd0))

endmodule

bind dual_slot_record_validator dsrv_checker u_dsrv_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .opcode         (opcode),
  .last_byte      (last_byte),
  .done           (done),
  .result_kind    (result_kind),
  .slot_ok        (slot_ok),
  .action         (action),
  .write_sequence (write_sequence),
  .active_source  (active_source),
  .use_defaults   (use_defaults)
);

FILE: bench/tb.sv
// self-checking testbench of the dual slot record validator: directed rows, then random records
module tb;
  import dsrv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_GOAL = 500;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    op_t        op;
    logic       slot;
    logic [7:0] data;
    logic       last;
    logic       wok;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic        ok;
    act_t        act;
    logic        wslot;
    logic [31:0] wseq;
    src_t        src;
    logic [31:0] aseq;
    logic        usedef;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t want;
  } row_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_SIZE,
    FLAW_CRC,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_SLOT_SWAP,
    FLAW_INTERLEAVE,
    FLAW_OVERLONG
  } flaw_t;

  localparam resp_t FRESH_DECIDE =
    '{KIND_DECISION, 1'b0, ACT_DEFAULTS, 1'b0, 32'd1, SRC_DEFAULTS, 32'd0, 1'b1};
  localparam resp_t FRESH_SAVE =
    '{KIND_PLAN, 1'b0, ACT_SAVE, 1'b0, 32'd1, SRC_DEFAULTS, 32'd0, 1'b1};
  localparam resp_t IDLE_COMMIT =
    '{KIND_COMMIT, 1'b0, ACT_NONE, 1'b0, 32'd1, SRC_DEFAULTS, 32'd0, 1'b1};
  localparam resp_t FAILED_CHECK =
    '{KIND_CHECK, 1'b0, ACT_NONE, 1'b0, 32'd1, SRC_DEFAULTS, 32'd0, 1'b1};
  localparam resp_t LIVE = '0;

  localparam row_t STIM_ROWS [19] = '{
    '{'{OP_DECIDE, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, FRESH_DECIDE},
    '{'{OP_SAVE,   1'b1, 8'hFF, 1'b1, 1'b1}, 1'b1, FRESH_SAVE},
    '{'{OP_COMMIT, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, IDLE_COMMIT},
    '{'{OP_COMMIT, 1'b1, 8'hFF, 1'b1, 1'b1}, 1'b1, IDLE_COMMIT},
    '{'{OP_BYTE,   1'b1, 8'hFF, 1'b1, 1'b0}, 1'b1, FAILED_CHECK},
    '{'{OP_BYTE,   1'b0, 8'h00, 1'b1, 1'b1}, 1'b1, FAILED_CHECK},
    '{'{OP_BYTE,   1'b0, 8'h4D, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_BYTE,   1'b1, 8'hAA, 1'b1, 1'b0}, 1'b1, FAILED_CHECK},
    '{'{OP_DECIDE, 1'b1, 8'h55, 1'b0, 1'b1}, 1'b0, LIVE},
    '{'{OP_COMMIT, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, LIVE},
    '{'{OP_DECIDE, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_SAVE,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_COMMIT, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, LIVE},
    '{'{OP_DECIDE, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_SAVE,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_COMMIT, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_SAVE,   1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE},
    '{'{OP_COMMIT, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, LIVE},
    '{'{OP_DECIDE, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, LIVE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_BYTE;
  logic        slot = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        write_ok = 1'b0;
  logic        wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = REG_PAYLOAD_BYTES;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic        done;
  logic [1:0]  result_kind;
  logic        slot_ok;
  logic [1:0]  action;
  logic        write_slot;
  logic [31:0] write_sequence;
  logic [1:0]  active_source;
  logic [31:0] active_sequence;
  logic        use_defaults;

  // predictor copy of the block
  logic [11:0]        cfg_payload = 12'd64;
  logic [31:0]        cfg_revision = 32'd1;
  logic [31:0]        stream_crc = CRC_INIT;
  logic [COUNT_W-1:0] stream_count = '0;
  logic [63:0]        hdr_lo = '0;
  logic [63:0]        hdr_hi = '0;
  logic [31:0]        stored_crc = '0;
  logic [31:0]        slot_seq [2] = '{32'd0, 32'd0};
  logic [31:0]        slot_rev [2] = '{32'd0, 32'd0};
  logic               slot_good [2] = '{1'b0, 1'b0};
  src_t               live_src = SRC_DEFAULTS;
  logic [31:0]        live_seq = '0;
  logic               plan_valid = 1'b0;
  logic               plan_slot = 1'b0;
  logic [31:0]        plan_seq = '0;

  resp_t expected_outcomes [$];
  resp_t seen;
  resp_t wanted;
  int    items_sent = 0;
  int    mismatches = 0;
  int    cycle_count = 0;
  bit    gappy = 1'b1;

  dual_slot_record_validator DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .slot(slot),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .write_ok(write_ok),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .result_kind(result_kind),
    .slot_ok(slot_ok),
    .action(action),
    .write_slot(write_slot),
    .write_sequence(write_sequence),
    .active_source(active_source),
    .active_sequence(active_sequence),
    .use_defaults(use_defaults)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [31:0] bump_sequence(input logic [31:0] s);
    logic [31:0] n;
    n = s + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

  function automatic resp_t outcome(input kind_t k, input logic ok, input act_t a,
                                    input logic ws, input logic [31:0] wq);
    return '{k, ok, a, ws, wq, live_src, live_seq, live_src == SRC_DEFAULTS};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFE;
      3: return 32'($urandom_range(1, 5));
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_ctrl();
    req_t r;
    r.slot = 1'($urandom);
    r.data = 8'($urandom);
    r.last = 1'($urandom);
    r.wok = ($urandom_range(0, 9) < 7);
    case ($urandom_range(0, 2))
      0: r.op = OP_DECIDE;
      1: r.op = OP_SAVE;
      default: r.op = OP_COMMIT;
    endcase
    return r;
  endfunction

  task automatic predict_outcome(input req_t r, output bit has, output resp_t res);
    logic ok;
    int sel;
    int s;
    logic [31:0] ws;
    logic [31:0] wq;
    has = 1'b1;
    res = '0;
    case (r.op)
      OP_BYTE: begin
        if (stream_count < 8) hdr_lo |= 64'(r.data) << (8 * stream_count);
        else if (stream_count < 16) hdr_hi |= 64'(r.data) << (8 * (stream_count - 8));
        else if (stream_count < HEADER_BYTES)
          stored_crc |= 32'(r.data) << (8 * (stream_count - 16));
        else stream_crc = crc32_step(stream_crc, r.data);
        if (stream_count != COUNT_MAX) stream_count++;
        if (!r.last) begin
          has = 1'b0;
        end else begin
          ok = hdr_lo[31:0] == REC_MAGIC && hdr_lo[47:32] == REC_VERSION &&
               hdr_lo[63:48] == 16'(cfg_payload) &&
               int'(stream_count) == HEADER_BYTES + int'(cfg_payload) &&
               int'(stream_count) <= MAX_RECORD_BYTES && ~stream_crc == stored_crc;
          slot_good[r.slot] = ok;
          slot_seq[r.slot] = hdr_hi[31:0];
          slot_rev[r.slot] = hdr_hi[63:32];
          stream_crc = CRC_INIT;
          stream_count = '0;
          hdr_lo = '0;
          hdr_hi = '0;
          stored_crc = '0;
          res = outcome(KIND_CHECK, ok, ACT_NONE, 1'b0, 32'd1);
        end
      end
      OP_DECIDE: begin
        sel = 2;
        plan_valid = 1'b0;
        live_src = SRC_DEFAULTS;
        live_seq = '0;
        for (s = 0; s < 2; s++) begin
          if (slot_good[s] && (sel == 2 || slot_rev[s] > slot_rev[sel] ||
              (slot_rev[s] == slot_rev[sel] && slot_seq[s] > slot_seq[sel])))
            sel = s;
        end
        if (sel == 2) begin
          plan_valid = 1'b1;
          plan_slot = 1'b0;
          plan_seq = 32'd1;
          res = outcome(KIND_DECISION, 1'b0, ACT_DEFAULTS, 1'b0, 32'd1);
        end else if (slot_rev[sel] < cfg_revision) begin
          // outdated record: rewrite slot 0, keep defaults active
          plan_valid = 1'b1;
          plan_slot = 1'b0;
          plan_seq = bump_sequence(slot_seq[sel]);
          res = outcome(KIND_DECISION, 1'b0, ACT_DEFAULTS, 1'b0, plan_seq);
        end else begin
          live_src = src_t'(sel + 1);
          live_seq = slot_seq[sel];
          if (slot_good[0] != slot_good[1]) begin
            plan_valid = 1'b1;
            plan_slot = 1'(sel ^ 1);
            plan_seq = bump_sequence(live_seq);
            res = outcome(KIND_DECISION, 1'b0, ACT_REPAIR, plan_slot, plan_seq);
          end else begin
            res = outcome(KIND_DECISION, 1'b0, ACT_NONE, 1'b0, 32'd1);
          end
        end
      end
      OP_SAVE: begin
        if (live_src == SRC_DEFAULTS) begin
          plan_slot = 1'b0;
          plan_seq = 32'd1;
        end else begin
          plan_slot = (live_src == SRC_SLOT1) ? 1'b0 : 1'b1;
          plan_seq = bump_sequence(live_seq);
        end
        plan_valid = 1'b1;
        res = outcome(KIND_PLAN, 1'b0, ACT_SAVE, plan_slot, plan_seq);
      end
      default: begin
        ws = '0;
        wq = 32'd1;
        if (plan_valid && r.wok) begin
          live_src = plan_slot ? SRC_SLOT1 : SRC_SLOT0;
          live_seq = plan_seq;
          slot_good[plan_slot] = 1'b1;
          slot_seq[plan_slot] = plan_seq;
          slot_rev[plan_slot] = cfg_revision;
          ws = 32'(plan_slot);
          wq = plan_seq;
        end
        plan_valid = 1'b0;
        plan_slot = 1'b0;
        plan_seq = '0;
        res = outcome(KIND_COMMIT, 1'b0, ACT_NONE, ws[0], wq);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input req_t r, input bit typed, input resp_t typed_want);
    bit has;
    resp_t res;
    start <= 1'b1;
    opcode <= r.op;
    slot <= r.slot;
    data_byte <= r.data;
    last_byte <= r.last;
    write_ok <= r.wok;
    do @(posedge clk); while (busy);
    predict_outcome(r, has, res);
    items_sent++;
    if (has) begin
      expected_outcomes.push_back(typed ? typed_want : res);
    end
    if (gappy && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_record(input logic s, input logic [31:0] seq_no,
                             input logic [31:0] rev, input flaw_t flaw);
    logic [7:0] rec_bytes [$];
    logic [7:0] pay_bytes [$];
    logic [31:0] magic;
    logic [31:0] crc_word;
    logic [15:0] ver;
    logic [15:0] size_field;
    logic [159:0] header;
    int cut;
    int wrong_slot_bytes;
    int split;
    int i;
    req_t r;
    magic = REC_MAGIC;
    ver = REC_VERSION;
    size_field = 16'(cfg_payload);
    crc_word = CRC_INIT;
    cut = 0;
    wrong_slot_bytes = 0;
    split = -1;
    repeat (cfg_payload) begin
      pay_bytes.push_back(8'($urandom));
      crc_word = crc32_step(crc_word, pay_bytes[$]);
    end
    crc_word = ~crc_word;
    case (flaw)
      FLAW_MAGIC: magic ^= 32'd1 << $urandom_range(0, 31);
      FLAW_VERSION: ver ^= 16'd1 << $urandom_range(0, 15);
      FLAW_SIZE: size_field ^= 16'd1 << $urandom_range(0, 15);
      FLAW_CRC: crc_word ^= 32'd1 << $urandom_range(0, 31);
      FLAW_SHORT: cut = $urandom_range(1, 8);
      FLAW_LONG: repeat ($urandom_range(1, 8)) pay_bytes.push_back(8'($urandom));
      // enough extra bytes to saturate the byte counter
      FLAW_OVERLONG: repeat (8200) pay_bytes.push_back(8'($urandom));
      FLAW_SLOT_SWAP: wrong_slot_bytes = $urandom_range(1, HEADER_BYTES + cfg_payload - 1);
      FLAW_INTERLEAVE: split = $urandom_range(1, HEADER_BYTES + cfg_payload - 1);
      default: ;
    endcase
    header = {crc_word, rev, seq_no, size_field, ver, magic};
    for (i = 0; i < HEADER_BYTES; i++) rec_bytes.push_back(header[8*i +: 8]);
    foreach (pay_bytes[j]) rec_bytes.push_back(pay_bytes[j]);
    repeat (cut) void'(rec_bytes.pop_back());
    for (i = 0; i < rec_bytes.size(); i++) begin
      if (i == split) send_item(random_ctrl(), 1'b0, LIVE);
      r.op = OP_BYTE;
      r.slot = (i < wrong_slot_bytes) ? ~s : s;
      r.data = rec_bytes[i];
      r.last = (i == rec_bytes.size() - 1);
      r.wok = 1'($urandom);
      send_item(r, 1'b0, LIVE);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen = '{kind_t'(result_kind), slot_ok, act_t'(action), write_slot, write_sequence,
               src_t'(active_source), active_sequence, use_defaults};
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with none expected, kind", 32'(seen.kind), 32'd0);
      end else begin
        wanted = expected_outcomes.pop_front();
        if (seen.kind !== wanted.kind)
          report_mismatch("result_kind", 32'(seen.kind), 32'(wanted.kind));
        if (seen.ok !== wanted.ok) report_mismatch("slot_ok", 32'(seen.ok), 32'(wanted.ok));
        if (seen.act !== wanted.act)
          report_mismatch("action", 32'(seen.act), 32'(wanted.act));
        if (seen.wslot !== wanted.wslot)
          report_mismatch("write_slot", 32'(seen.wslot), 32'(wanted.wslot));
        if (seen.wseq !== wanted.wseq) report_mismatch("write_sequence", seen.wseq, wanted.wseq);
        if (seen.src !== wanted.src)
          report_mismatch("active_source", 32'(seen.src), 32'(wanted.src));
        if (seen.aseq !== wanted.aseq)
          report_mismatch("active_sequence", seen.aseq, wanted.aseq);
        if (seen.usedef !== wanted.usedef)
          report_mismatch("use_defaults", 32'(seen.usedef), 32'(wanted.usedef));
      end
    end
  end

  initial begin
    int phase;
    int pick;
    int w;
    logic [11:0] pay;
    logic [31:0] rev;
    logic [31:0] rec_rev;
    req_t noise;
    bit quiet;
    bit quiet_done;
    phase = 0;
    quiet = 1'b0;
    quiet_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (STIM_ROWS[n]) send_item(STIM_ROWS[n].req, STIM_ROWS[n].typed, STIM_ROWS[n].want);

    while (phase < 2 || !quiet_done) begin
      // registers change only with the block idle
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (phase)
        0: begin
          pay = 12'd1;
          rev = 32'd0;
        end
        1: begin
          pay = 12'd4076;
          rev = 32'hFFFF_FFFF;
        end
        default: begin
          pay = ($urandom_range(0, 7) == 0) ? 12'd64 : 12'($urandom_range(1, 16));
          rev = pick_word();
        end
      endcase
      wr_en <= 1'b1;
      wr_index <= REG_PAYLOAD_BYTES;
      wr_data <= 32'(pay);
      @(posedge clk);
      cfg_payload = pay;
      wr_index <= REG_CODE_REVISION;
      wr_data <= rev;
      @(posedge clk);
      cfg_revision = rev;
      wr_en <= 1'b0;
      gappy = !quiet && ($urandom_range(0, 3) != 0);

      if (phase == 1) begin
        // largest payload a valid record can carry, with short records and control items
        repeat (8) begin
          noise.op = OP_BYTE;
          noise.slot = 1'($urandom);
          noise.data = 8'($urandom);
          noise.last = ($urandom_range(0, 3) == 0);
          noise.wok = 1'($urandom);
          send_item(noise, 1'b0, LIVE);
        end
        repeat (4) send_item(random_ctrl(), 1'b0, LIVE);
      end else begin
        repeat (12) begin
          pick = $urandom_range(0, 99);
          rec_rev = ($urandom_range(0, 3) == 0) ? pick_word()
                  : cfg_revision + 32'($urandom_range(0, 2)) - 32'd1;
          if (pick < 45) begin
            send_record(1'($urandom), pick_word(), rec_rev, FLAW_NONE);
          end else if (pick < 60) begin
            send_record(1'($urandom), pick_word(), rec_rev,
                        flaw_t'($urandom_range(FLAW_MAGIC, FLAW_INTERLEAVE)));
          end else if (pick < 94) begin
            send_item(random_ctrl(), 1'b0, LIVE);
          end else begin
            noise.op = OP_BYTE;
            noise.slot = 1'($urandom);
            noise.data = 8'($urandom);
            noise.last = ($urandom_range(0, 3) != 0);
            noise.wok = 1'($urandom);
            send_item(noise, 1'b0, LIVE);
          end
        end
      end
      phase++;
      quiet_done = quiet;
      quiet = items_sent >= ITEM_GOAL - 250;
    end

    start <= 1'b0;
    for (w = 0; w < 1000 && expected_outcomes.size() != 0; w++) @(posedge clk);
    if (expected_outcomes.size() != 0)
      report_mismatch("results never arrived, count", 32'(expected_outcomes.size()), 32'd0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: dual_slot_record_validator.f
+incdir+rtl
rtl/dsrv_pkg.sv
rtl/dsrv_front.sv
rtl/dsrv_queue.sv
rtl/dsrv_back.sv
rtl/dual_slot_record_validator.sv
rtl/dsrv_checker.sv
bench/tb.sv
